// File: src/s2h_pkg.sv
// Package for the single-to-half float converter.
// Holds the exponent thresholds and field widths used by the converter and top level.
// No dependencies.
package s2h_pkg;

  localparam int SINGLE_W = 32;
  localparam int HALF_W   = 16;

  // Biased single exponent thresholds
  localparam logic [7:0] EXP_OVER_LIMIT   = 8'h8F;  // above this: saturate
  localparam logic [7:0] EXP_NORMAL_FLOOR = 8'h70;  // at or below: half denormal/zero
  localparam logic [7:0] EXP_DENORM_FLOOR = 8'h67;  // lowest exponent of denormal range
  localparam logic [7:0] EXP_TINY         = 8'h66;  // just below smallest denormal

  localparam logic [14:0] HALF_MAX_MAG = 15'h7BFF;
  localparam logic [4:0]  HALF_EXP_TOP = 5'h1F;

endpackage

// File: src/s2h_convert.sv
// Combinational binary32 to binary16 conversion, round to nearest even, saturating.
// Depends on s2h_pkg.
module s2h_convert
  import s2h_pkg::*;
(
  input  logic [SINGLE_W-1:0] single_bits,
  output logic [HALF_W-1:0]   half_bits
);

  logic        sign;
  logic [7:0]  exp_s;
  logic [22:0] man_s;
  logic [7:0]  den_off;
  logic [7:0]  nrm_off;
  logic [32:0] den_t;
  logic        den_rnd;
  logic [10:0] den_sum;
  logic        nrm_rnd;
  logic [10:0] nrm_sum;
  logic [5:0]  nrm_exp;
  logic [14:0] mag;

  always_comb begin
    sign  = single_bits[31];
    exp_s = single_bits[30:23];
    man_s = single_bits[22:0];

    // Denormal path: align hidden-bit mantissa, value in units of 2^-24
    den_off = exp_s - EXP_DENORM_FLOOR;
    den_t   = {9'b0, 1'b1, man_s} << den_off[3:0];
    den_rnd = den_t[22] && ((den_t[21:0] != '0) || den_t[23]);
    den_sum = {1'b0, den_t[32:23]} + {10'b0, den_rnd};

    // Normal path: drop 13 mantissa bits
    nrm_off = exp_s - EXP_NORMAL_FLOOR;
    nrm_rnd = man_s[12] && ((man_s[11:0] != '0) || man_s[13]);
    nrm_sum = {1'b0, man_s[22:13]} + {10'b0, nrm_rnd};
    nrm_exp = {1'b0, nrm_off[4:0]} + {5'b0, nrm_sum[10]};

    if (exp_s > EXP_OVER_LIMIT) begin
      mag = HALF_MAX_MAG;
    end else if (exp_s <= EXP_NORMAL_FLOOR) begin
      if (exp_s >= EXP_DENORM_FLOOR) begin
        // a carry to 0x400 is already the smallest normal pattern
        mag = {4'b0, den_sum};
      end else if (exp_s == EXP_TINY && man_s != '0) begin
        mag = 15'd1;
      end else begin
        mag = '0;
      end
    end else if (nrm_exp >= {1'b0, HALF_EXP_TOP}) begin
      mag = HALF_MAX_MAG;
    end else begin
      mag = {nrm_exp[4:0], nrm_sum[10] ? 10'b0 : nrm_sum[9:0]};
    end

    half_bits = {sign, mag};
  end

endmodule

// File: src/single_to_half_float_convert_unit.sv
// Top level of the single-to-half float converter: input register, conversion, result register.
// Depends on s2h_pkg and s2h_convert.
// Each accepted transaction passes through the input register and then the result register,
// and out_valid rises once the result register has been loaded.
// Throughput: one transaction per cycle, sustained while out_ready stays high.
// Reset (rst_n, synchronous, active low) clears both stage valid flags; payload is not reset.
module single_to_half_float_convert_unit
  import s2h_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SINGLE_W-1:0] in_single_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HALF_W-1:0]   out_half_bits
);

  // Stage 1: captured input pattern
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [SINGLE_W-1:0] s1_bits_r;
  // Stage 2: result register
  logic                s2_valid_r;
  logic                s2_valid_nxt;
  logic [HALF_W-1:0]   s2_bits_r;

  logic                s2_take;
  logic                s1_take;
  logic [HALF_W-1:0]   conv_bits;

  // The result register takes a new value whenever it is empty or being drained;
  // the input register likewise, so a waiting result never blocks one transaction in flight.
  assign s2_take  = !s2_valid_r || out_ready;
  assign s1_take  = !s1_valid_r || s2_take;
  assign in_ready = s1_take;

  s2h_convert u_convert (
    .single_bits (s1_bits_r),
    .half_bits   (conv_bits)
  );

  always_comb begin
    s1_valid_nxt = s1_take ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_take ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_bits_r <= in_single_bits;
    end
    if (s2_take && s1_valid_r) begin
      s2_bits_r <= conv_bits;
    end
  end

  assign out_valid     = s2_valid_r;
  assign out_half_bits = s2_bits_r;

  // An accepted transaction lands in the input register
  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction not held in input register");

  // A filled input register moves to the result register when it can
  a_s2_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_take |=> s2_valid_r)
    else $error("input register not passed to result register");

  // Sign carries through unchanged
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_take |=> out_half_bits[15] == $past(s1_bits_r[31]))
    else $error("sign lost in conversion");

  // Results saturate, never infinity or NaN
  a_no_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_half_bits[14:10] != HALF_EXP_TOP)
    else $error("result exponent all ones");

endmodule
